>>> rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and constants of the timer deadline queue
// Actions, result kinds, sequencer states and queue sizing.
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int CAPACITY = 32;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [31:0] WAIT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WAIT_EMPTY = 32'hFFFF_FFFF;
  localparam int EW = 96;

  typedef enum logic [1:0] {
    ACT_SCHED = 2'd0,
    ACT_FIRE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RK_ACK   = 2'd0,
    RK_FIRED = 2'd1,
    RK_DONE  = 2'd2,
    RK_WAIT  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,    // search: read entry at index
    ST_SCMP,   // search: compare read entry
    ST_SHRD,   // shift up: read entry below
    ST_SHWR,   // shift up: write entry one higher
    ST_INS,    // write new entry
    ST_FRD,    // fire: read head candidate
    ST_FCMP,   // fire: compare and emit
    ST_CRD,    // compact: read entry
    ST_CWR,    // compact: write entry lower
    ST_DONE,
    ST_QRD,
    ST_QCMP
  } state_t;

endpackage

>>> rtl/timer_deadline_queue.sv
// ----------------------------------------------------------------------------
// timer_deadline_queue: sorted store of pending timers, earliest first
// Schedule, fire and query requests served by a sequencer over one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the operation has finished its RAM work (a refused schedule, an empty
// query or an unused action never raises it). A schedule is acknowledged in the
// cycle it is taken, and the sorted insert runs afterwards under busy; fire and
// non-empty query results come later, and busy drops right after the last one.
// Results appear for one cycle each on out_valid and cannot be held off.
// Timers live sorted by (deadline, id) in a single-port RAM; one shared 96-bit
// compare unit checks one entry per step. A schedule searches the stored entries
// in order, then moves the later entries up one place and writes the new one. A
// fire reads and emits each expired timer, then moves the remaining entries down.
// A query reads the head entry. Every memory access goes through the one RAM port.
module timer_deadline_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [63:0]           in_time_value,
  output logic                  out_valid,
  output logic [1:0]            out_result_kind,
  output logic [31:0]           out_timer_id,
  output logic [5:0]            out_fired_count,
  output logic signed [31:0]    out_wait_ms,
  output logic                  out_queue_full,
  output logic                  out_last
);
  import tdq_pkg::*;

  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // entries stored
  logic [CW-1:0] idx_r, idx_nxt;       // walking index
  logic [CW-1:0] fired_r, fired_nxt;   // fired in this pass / insert position
  logic [31:0]   nid_r, nid_nxt;
  logic [63:0]   t_r;
  logic [31:0]   tid_r;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [63:0]   rd_dl;
  logic [31:0]   rd_id;

  tdq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rd_dl = rdata[95:32];
  assign rd_id = rdata[31:0];

  // Shared compare unit: new entry earlier than stored, and stored expired.
  logic new_earlier, expired;
  logic [64:0] diff;
  assign new_earlier = (t_r < rd_dl) || ((t_r == rd_dl) && (tid_r < rd_id));
  assign expired = rd_dl <= t_r;
  assign diff = {1'b0, rd_dl} - {1'b0, t_r};

  assign busy = (st_r != ST_IDLE);

  // Next state and bookkeeping.
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    fired_nxt = fired_r;
    nid_nxt = nid_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt = '0;
          fired_nxt = '0;
          unique case (action_t'(in_action))
            ACT_SCHED: begin
              if (cnt_r != CW'(CAPACITY)) begin
                nid_nxt = nid_r + 32'd1;
                st_nxt = (cnt_r == '0) ? ST_INS : ST_SRD;
              end
            end
            ACT_FIRE:  st_nxt = (cnt_r == '0) ? ST_DONE : ST_FRD;
            ACT_QUERY: st_nxt = (cnt_r == '0) ? ST_IDLE : ST_QRD;
            default:   st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRD: st_nxt = ST_SCMP;
      ST_SCMP: begin
        priority if (new_earlier) begin
          fired_nxt = idx_r;
          idx_nxt = cnt_r;
          st_nxt = ST_SHRD;
        end else if (idx_r + 1'b1 == cnt_r) begin
          fired_nxt = cnt_r;
          st_nxt = ST_INS;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = ST_SRD;
        end
      end
      ST_SHRD: st_nxt = ST_SHWR;
      ST_SHWR: begin
        idx_nxt = idx_r - 1'b1;
        st_nxt = (idx_r - 1'b1 == fired_r) ? ST_INS : ST_SHRD;
      end
      ST_INS: begin
        cnt_nxt = cnt_r + 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_FRD: st_nxt = ST_FCMP;
      ST_FCMP: begin
        priority if (expired) begin
          fired_nxt = fired_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
          st_nxt = (idx_r + 1'b1 == cnt_r) ? ST_DONE : ST_FRD;
        end else begin
          st_nxt = (fired_r == '0) ? ST_DONE : ST_CRD;
        end
      end
      ST_CRD: st_nxt = ST_CWR;
      ST_CWR: begin
        idx_nxt = idx_r + 1'b1;
        st_nxt = (idx_r + 1'b1 == cnt_r) ? ST_DONE : ST_CRD;
      end
      ST_DONE: begin
        cnt_nxt = cnt_r - fired_r;
        st_nxt = ST_IDLE;
      end
      ST_QRD: st_nxt = ST_QCMP;
      ST_QCMP: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // RAM port and result outputs.
  always_comb begin
    we = 1'b0;
    addr = idx_r[AW-1:0];
    wdata = rdata;
    out_valid = 1'b0;
    out_result_kind = RK_ACK;
    out_timer_id = '0;
    out_fired_count = '0;
    out_wait_ms = '0;
    out_queue_full = 1'b0;
    out_last = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          unique case (action_t'(in_action))
            ACT_SCHED: begin
              out_valid = 1'b1;
              out_last = 1'b1;
              if (cnt_r == CW'(CAPACITY)) out_queue_full = 1'b1;
              else out_timer_id = nid_r;
            end
            ACT_QUERY: begin
              if (cnt_r == '0) begin
                out_valid = 1'b1;
                out_last = 1'b1;
                out_result_kind = RK_WAIT;
                out_wait_ms = WAIT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHRD: addr = AW'(idx_r - 1'b1);
      ST_SHWR: we = 1'b1;
      ST_INS: begin
        we = 1'b1;
        addr = fired_r[AW-1:0];
        wdata = {t_r, tid_r};
      end
      ST_FCMP: begin
        if (expired) begin
          out_valid = 1'b1;
          out_result_kind = RK_FIRED;
          out_timer_id = rd_id;
        end
      end
      ST_CWR: begin
        we = 1'b1;
        addr = AW'(idx_r - fired_r);
      end
      ST_DONE: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        out_result_kind = RK_DONE;
        out_fired_count = 6'(fired_r);
      end
      ST_QRD: addr = '0;
      ST_QCMP: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        out_result_kind = RK_WAIT;
        priority if (expired) out_wait_ms = '0;
        else if (diff > 65'(WAIT_MAX)) out_wait_ms = WAIT_MAX;
        else out_wait_ms = diff[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      fired_r <= '0;
      nid_r <= 32'd1;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      fired_r <= fired_nxt;
      nid_r <= nid_nxt;
    end
  end

  // Hold the request payload for the whole operation.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      t_r <= in_time_value;
      tid_r <= nid_r;
    end
  end

  // The stored count never exceeds capacity.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("count overflow");
  // Every last fire or query result returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_result_kind != RK_ACK) |=> !busy)
    else $error("busy after last");
  // A fired result never exceeds what is stored.
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_FIRED) |-> (fired_r < cnt_r))
    else $error("fired beyond count");
endmodule

>>> rtl/tdq_ram.sv
// ----------------------------------------------------------------------------
// tdq_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> tb/timer_deadline_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue_test: self-checking bench for the timer deadline queue
// Drives schedule, fire and query requests, keeps a sorted shadow queue of
// pending timers and compares every result strobe against its prediction.
// ----------------------------------------------------------------------------
module timer_deadline_queue_test;
  import tdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_REQUESTS = 384;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        timer_id;
    logic [5:0]         fired_count;
    logic signed [31:0] wait_ms;
    logic               queue_full;
    logic               last;
  } timer_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_action;
  logic [63:0]        in_time_value;
  logic               out_valid;
  logic [1:0]         out_result_kind;
  logic [31:0]        out_timer_id;
  logic [5:0]         out_fired_count;
  logic signed [31:0] out_wait_ms;
  logic               out_queue_full;
  logic               out_last;

  // Shadow of the queue: entries sorted by (deadline, id), earliest first.
  logic [63:0]   shadow_deadline[CAPACITY];
  logic [31:0]   shadow_id[CAPACITY];
  int            shadow_count;
  logic [31:0]   shadow_next_id;

  timer_result_t pending_results[$];
  int            error_count;
  int            idle_pct;
  int            quiet_cycles;
  logic [63:0]   now_ms;

  timer_deadline_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_time_value   (in_time_value),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_timer_id    (out_timer_id),
    .out_fired_count (out_fired_count),
    .out_wait_ms     (out_wait_ms),
    .out_queue_full  (out_queue_full),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build one expected result.
  function automatic timer_result_t make_result(kind_t kind, logic [31:0] id,
                                                logic [5:0] cnt,
                                                logic [31:0] wt, logic full,
                                                logic lst);
    timer_result_t r;
    r.kind        = kind;
    r.timer_id    = id;
    r.fired_count = cnt;
    r.wait_ms     = wt;
    r.queue_full  = full;
    r.last        = lst;
    return r;
  endfunction

  // Apply one accepted request to the shadow queue and queue its results.
  task automatic predict_timer_request(action_t act, logic [63:0] t);
    int          pos;
    int          fired;
    logic [31:0] id;
    logic [63:0] delta;
    logic [31:0] wt;
    case (act)
      ACT_SCHED: begin
        if (shadow_count >= CAPACITY) begin
          // full: nothing stored, id counter holds
          pending_results.push_back(make_result(RK_ACK, '0, '0, '0, 1'b1, 1'b1));
        end else begin
          id = shadow_next_id;
          shadow_next_id = shadow_next_id + 32'd1;
          pos = 0;
          // ties order by numeric id
          while (pos < shadow_count &&
                 !(t < shadow_deadline[pos] ||
                   (t == shadow_deadline[pos] && id < shadow_id[pos])))
            pos++;
          for (int j = shadow_count; j > pos; j--) begin
            shadow_deadline[j] = shadow_deadline[j-1];
            shadow_id[j]       = shadow_id[j-1];
          end
          shadow_deadline[pos] = t;
          shadow_id[pos]       = id;
          shadow_count++;
          pending_results.push_back(make_result(RK_ACK, id, '0, '0, 1'b0, 1'b1));
        end
      end
      ACT_FIRE: begin
        fired = 0;
        while (fired < shadow_count && shadow_deadline[fired] <= t) begin
          pending_results.push_back(make_result(RK_FIRED, shadow_id[fired], '0, '0,
                                                1'b0, 1'b0));
          fired++;
        end
        // compact the survivors to the front
        for (int j = fired; j < shadow_count; j++) begin
          shadow_deadline[j-fired] = shadow_deadline[j];
          shadow_id[j-fired]       = shadow_id[j];
        end
        shadow_count -= fired;
        pending_results.push_back(make_result(RK_DONE, '0, 6'(fired), '0, 1'b0, 1'b1));
      end
      ACT_QUERY: begin
        if (shadow_count == 0) begin
          wt = WAIT_EMPTY;
        end else if (shadow_deadline[0] <= t) begin
          wt = '0;
        end else begin
          delta = shadow_deadline[0] - t;
          wt = (delta > 64'(WAIT_MAX)) ? WAIT_MAX : delta[31:0];
        end
        pending_results.push_back(make_result(RK_WAIT, '0, '0, wt, 1'b0, 1'b1));
      end
      default: begin
        // unused action: no state change, no result
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Send one request: optional gap, then hold start until the edge that takes it.
  // Busy only moves at the rising edge, so its value at the falling edge tells
  // whether the next rising edge takes the request.
  task automatic send_request(action_t act, logic [63:0] t);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start         = 1'b1;
    in_action     = act;
    in_time_value = t;
    while (busy) @(negedge clk);
    predict_timer_request(act, t);
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Hold until every predicted result has come and the block is idle.
  task automatic drain_results();
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Deadline near the running clock, sometimes a tie, sometimes whole 2^32 steps ahead, sometimes anywhere.
  function automatic logic [63:0] pick_deadline();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return now_ms + 64'($urandom_range(0, 3000));
    if (sel < 82 && shadow_count != 0)
      return shadow_deadline[$urandom_range(0, shadow_count - 1)];
    if (sel < 90) return now_ms + 64'($urandom_range(0, 3)) * 64'h1_0000_0000;
    return {$urandom, $urandom};
  endfunction

  // Check each result strobe against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("ERROR @%0t: result with nothing expected", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind != want.kind)
          report_mismatch("result_kind", out_result_kind, want.kind);
        if (out_timer_id != want.timer_id)
          report_mismatch("timer_id", out_timer_id, want.timer_id);
        if (out_fired_count != want.fired_count)
          report_mismatch("fired_count", out_fired_count, want.fired_count);
        if (out_wait_ms != want.wait_ms)
          report_mismatch("wait_ms", out_wait_ms, want.wait_ms);
        if (out_queue_full != want.queue_full)
          report_mismatch("queue_full", out_queue_full, want.queue_full);
        if (out_last != want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog: count cycles in which no request is taken and no result shows.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timer_deadline_queue test failed");
        $finish;
      end
    end
  end

  // Empty queue: query reports empty, fire with nothing pending, and an unused action.
  task automatic test_empty_queue();
    send_request(ACT_QUERY, 64'd0);
    send_request(ACT_FIRE, '1);
    send_request(ACT_NONE, 64'd5);
  endtask

  // Fill to capacity with extremes and ties, querying on the way, then refuse two more.
  task automatic test_fill_and_full();
    send_request(ACT_SCHED, '1);
    send_request(ACT_SCHED, 64'd0);
    send_request(ACT_SCHED, 64'd100);
    send_request(ACT_SCHED, 64'd100);
    send_request(ACT_QUERY, 64'd0);
    send_request(ACT_QUERY, '1);
    send_request(ACT_QUERY, 64'h8000_0000_0000_0000);
    for (int i = 4; i < CAPACITY; i++) send_request(ACT_SCHED, 64'(50 + 7 * i));
    send_request(ACT_SCHED, 64'd1);
    send_request(ACT_SCHED, 64'd2);
  endtask

  // Fire in stages: the zero deadline, then some more, then all remaining.
  task automatic test_fire_order();
    send_request(ACT_FIRE, 64'd0);
    send_request(ACT_FIRE, 64'd99);
    send_request(ACT_FIRE, 64'd100);
    send_request(ACT_QUERY, 64'd150);
    send_request(ACT_FIRE, '1);
    send_request(ACT_QUERY, 64'd0);
  endtask

  // Random traffic around an advancing clock, with noise and extremes.
  task automatic test_random_traffic(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        send_request(ACT_SCHED, pick_deadline());
      end else if (sel < 75) begin
        now_ms = now_ms + 64'($urandom_range(0, 1500));
        send_request(ACT_FIRE, ($urandom_range(19) == 0) ? {$urandom, $urandom} : now_ms);
      end else if (sel < 95) begin
        send_request(ACT_QUERY, ($urandom_range(9) == 0) ? {$urandom, $urandom} : now_ms);
      end else begin
        send_request(ACT_NONE, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    start         = 1'b0;
    in_action     = ACT_QUERY;
    in_time_value = '0;
    rst_n         = 1'b0;
    error_count   = 0;
    quiet_cycles  = 0;
    idle_pct      = 15;
    now_ms        = 64'd1000;
    shadow_count  = 0;
    shadow_next_id = 32'd1;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_deadline[i] = '0;
      shadow_id[i]       = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_fill_and_full();
    test_fire_order();
    test_random_traffic(RANDOM_REQUESTS / 3);
    idle_pct = 62;
    test_random_traffic(RANDOM_REQUESTS / 3);
    idle_pct = 0;
    test_random_traffic(RANDOM_REQUESTS / 3);

    drain_results();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("timer_deadline_queue test passed");
    end else begin
      $display("timer_deadline_queue test failed");
    end
    $finish;
  end

endmodule
